// File: sv/grid_dda_column_raycaster_assert.svh
// Assertion macros used by the raycaster checker.
// Both macros expect clk and rst_n to be visible where they are used.
`ifndef GRID_DDA_COLUMN_RAYCASTER_ASSERT_SVH
`define GRID_DDA_COLUMN_RAYCASTER_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define GDR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("raycaster check failed");

// Next-cycle implication, switched off while reset is held.
`define GDR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("raycaster check failed");

`endif

// File: sv/gdr_pkg.sv
`timescale 1ns / 1ps

package gdr_pkg;

  // Field widths fixed by the interface.
  localparam int DIR_FRAC = 14;
  localparam int POS_W    = 15;
  localparam int DIR_W    = 16;
  localparam int COL_W    = 10;
  localparam int REG_W    = 11;
  localparam int CELL_W   = 5;
  localparam int KIND_W   = 3;
  localparam int ROW_W    = 10;
  localparam int COLOR_W  = 8;

  // Internal arithmetic widths.
  localparam int CAM_W  = REG_W + DIR_FRAC;  // camera x magnitude
  localparam int RDM_W  = 27;                // ray component magnitude
  localparam int RD_W   = RDM_W + 1;         // signed ray component
  localparam int H_W    = 12;                // slice height, up to 2*rows+1

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS    = 1'b1;
  localparam logic [REG_W-1:0]     REG_RESET          = 11'd24;
  localparam logic [REG_W-1:0]     REG_MAX            = 11'd1024;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // Request handed from the front part to the back part.
  typedef struct packed {
    logic                     is_cast;
    logic [CELL_W-1:0]        cell_row;
    logic [CELL_W-1:0]        cell_col;
    logic [KIND_W-1:0]        kind;
    logic [COL_W-1:0]         column;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic signed [RD_W-1:0]   rdx;
    logic signed [RD_W-1:0]   rdy;
  } desc_t;

  // One result.
  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   draw_start;
    logic [ROW_W-1:0]   draw_end;
    logic [COLOR_W-1:0] color;
    logic               hit_side;
    logic               hit_found;
  } res_t;

  // Out-of-range register values act as the nearest legal value.
  function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v);
    logic [REG_W-1:0] r;
    if (v == '0) r = REG_W'(1);
    else if (v > REG_MAX) r = REG_MAX;
    else r = v;
    return r;
  endfunction

  // Wall colour by cell kind, halved on y sides.
  function automatic logic [COLOR_W-1:0] kind_color(input logic [KIND_W-1:0] kind,
                                                   input logic side);
    logic [COLOR_W-1:0] c;
    unique case (kind)
      3'd1:    c = 8'd204;
      3'd2:    c = 8'd238;
      3'd3:    c = 8'd17;
      3'd4:    c = 8'd34;
      default: c = 8'd51;
    endcase
    return side ? (c >> 1) : c;
  endfunction

endpackage

// File: sv/gdr_fifo.sv
`timescale 1ns / 1ps

// Small register queue; DEPTH is a power of two.
module gdr_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  T     wdata,
  input  logic pop,
  output logic empty,
  output T     rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (do_push && !do_pop) count_r <= count_r + CNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_W'(1);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

// File: sv/gdr_front.sv
`timescale 1ns / 1ps

// Front part: takes requests, forms the ray direction of a cast and passes
// every request on in order.
module gdr_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_op,
  input  logic [gdr_pkg::CELL_W-1:0]      in_cell_row,
  input  logic [gdr_pkg::CELL_W-1:0]      in_cell_col,
  input  logic [gdr_pkg::KIND_W-1:0]      in_cell_kind,
  input  logic [gdr_pkg::COL_W-1:0]       in_column,
  input  logic [gdr_pkg::POS_W-1:0]       in_pos_x,
  input  logic [gdr_pkg::POS_W-1:0]       in_pos_y,
  input  logic signed [gdr_pkg::DIR_W-1:0] in_dir_x,
  input  logic signed [gdr_pkg::DIR_W-1:0] in_dir_y,
  input  logic signed [gdr_pkg::DIR_W-1:0] in_plane_x,
  input  logic signed [gdr_pkg::DIR_W-1:0] in_plane_y,
  input  logic [gdr_pkg::REG_W-1:0]       scr_cols,
  output logic                            q_push,
  input  logic                            q_full,
  output gdr_pkg::desc_t                  q_data
);

  localparam int PROD_W = gdr_pkg::DIR_W + gdr_pkg::CAM_W;
  localparam int CNT_W  = $clog2(gdr_pkg::CAM_W);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_DIV  = 3'd1;
  localparam logic [2:0] F_MUL  = 3'd2;
  localparam logic [2:0] F_ADD  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]                          state_r, state_nxt;
  gdr_pkg::desc_t                      desc_r;
  logic [CNT_W-1:0]                    cnt_r;
  logic [gdr_pkg::REG_W-1:0]           rem_r;
  logic [gdr_pkg::CAM_W-1:0]           dq_r;
  logic                                cam_neg_r;
  logic signed [gdr_pkg::DIR_W-1:0]    dx_r, dy_r, plx_r, ply_r;
  logic [PROD_W-1:0]                   prod_x_r, prod_y_r;
  logic                                neg_x_r, neg_y_r;

  logic signed [gdr_pkg::REG_W:0]      diff;
  logic [gdr_pkg::REG_W-1:0]           dmag;
  logic [gdr_pkg::REG_W:0]             rem_s, rem_sub;
  logic                                ge;
  logic [gdr_pkg::REG_W-1:0]           rem_nxt;
  logic [gdr_pkg::DIR_W-1:0]           plmx, plmy;
  logic [gdr_pkg::RDM_W-1:0]           termx, termy;
  logic signed [gdr_pkg::RD_W-1:0]     rdx_nxt, rdy_nxt;

  assign in_full = (state_r != F_IDLE);
  assign q_push  = (state_r == F_PUSH) && !q_full;
  assign q_data  = desc_r;

  // Signed numerator 2*column - columns and its magnitude.
  assign diff = $signed({1'b0, in_column, 1'b0}) - $signed({1'b0, scr_cols});
  assign dmag = gdr_pkg::REG_W'(diff[gdr_pkg::REG_W] ? -diff : diff);

  // One restoring division step per cycle.
  assign rem_s   = {rem_r, dq_r[gdr_pkg::CAM_W-1]};
  assign rem_sub = rem_s - {1'b0, scr_cols};
  assign ge      = (rem_s >= {1'b0, scr_cols});
  assign rem_nxt = ge ? rem_sub[gdr_pkg::REG_W-1:0] : rem_s[gdr_pkg::REG_W-1:0];

  // Plane magnitudes for the unsigned multiply.
  assign plmx = plx_r[gdr_pkg::DIR_W-1] ? gdr_pkg::DIR_W'(-plx_r) : gdr_pkg::DIR_W'(plx_r);
  assign plmy = ply_r[gdr_pkg::DIR_W-1] ? gdr_pkg::DIR_W'(-ply_r) : gdr_pkg::DIR_W'(ply_r);

  // Scaled plane term, truncated towards zero, added to the direction.
  assign termx   = prod_x_r[PROD_W-1:gdr_pkg::DIR_FRAC];
  assign termy   = prod_y_r[PROD_W-1:gdr_pkg::DIR_FRAC];
  assign rdx_nxt = gdr_pkg::RD_W'(dx_r) +
                   (neg_x_r ? -gdr_pkg::RD_W'(termx) : gdr_pkg::RD_W'(termx));
  assign rdy_nxt = gdr_pkg::RD_W'(dy_r) +
                   (neg_y_r ? -gdr_pkg::RD_W'(termy) : gdr_pkg::RD_W'(termy));

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_push) state_nxt = (in_op == gdr_pkg::OP_CAST) ? F_DIV : F_PUSH;
      end
      F_DIV: begin
        if (cnt_r == '0) state_nxt = F_MUL;
      end
      F_MUL:  state_nxt = F_ADD;
      F_ADD:  state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else state_r <= state_nxt;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (in_push) begin
          desc_r.is_cast  <= (in_op == gdr_pkg::OP_CAST);
          desc_r.cell_row <= in_cell_row;
          desc_r.cell_col <= in_cell_col;
          desc_r.kind     <= in_cell_kind;
          desc_r.column   <= in_column;
          desc_r.pos_x    <= in_pos_x;
          desc_r.pos_y    <= in_pos_y;
          dx_r            <= in_dir_x;
          dy_r            <= in_dir_y;
          plx_r           <= in_plane_x;
          ply_r           <= in_plane_y;
          cam_neg_r       <= diff[gdr_pkg::REG_W];
          dq_r            <= {dmag, gdr_pkg::DIR_FRAC'(0)};
          rem_r           <= '0;
          cnt_r           <= CNT_W'(gdr_pkg::CAM_W - 1);
        end
      end
      F_DIV: begin
        rem_r <= rem_nxt;
        dq_r  <= {dq_r[gdr_pkg::CAM_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      F_MUL: begin
        prod_x_r <= plmx * dq_r;
        prod_y_r <= plmy * dq_r;
        neg_x_r  <= cam_neg_r ^ plx_r[gdr_pkg::DIR_W-1];
        neg_y_r  <= cam_neg_r ^ ply_r[gdr_pkg::DIR_W-1];
      end
      F_ADD: begin
        desc_r.rdx <= rdx_nxt;
        desc_r.rdy <= rdy_nxt;
      end
      F_PUSH: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/gdr_back.sv
`timescale 1ns / 1ps

// Back part: owns the tile map, performs cell writes, walks the grid for a
// cast and turns the wall distance into a clipped slice.
module gdr_back #(
  parameter int MAP_DIM         = 32,
  parameter int COORD_FRAC_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  gdr_pkg::desc_t            q_data,
  input  logic [gdr_pkg::REG_W-1:0] rows,
  output logic                      o_push,
  input  logic                      o_full,
  output gdr_pkg::res_t             o_data
);

  localparam int F       = COORD_FRAC_BITS;
  localparam int DEPTH   = MAP_DIM * MAP_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LIMIT   = 2 * MAP_DIM;
  localparam int STEP_W  = $clog2(LIMIT + 1);
  localparam int A_W     = F + $clog2(LIMIT + 1) + 1;
  localparam int P_W     = A_W + gdr_pkg::RDM_W;
  localparam int MX_W    = ((gdr_pkg::POS_W > F) ? gdr_pkg::POS_W - F : 1) + STEP_W + 1;
  localparam int NR_W    = gdr_pkg::REG_W + gdr_pkg::RDM_W;
  localparam int NS_W    = NR_W + F;
  localparam int T_W     = gdr_pkg::H_W + A_W + gdr_pkg::DIR_FRAC;
  localparam int CMP_W   = (NS_W > T_W) ? NS_W : T_W;
  localparam int HC_W    = $clog2(gdr_pkg::H_W);
  localparam logic [A_W-1:0] ONE = A_W'(1) << F;
  localparam logic [gdr_pkg::POS_W-1:0] FRAC_MASK = gdr_pkg::POS_W'((64'd1 << F) - 64'd1);

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_INIT = 4'd1;
  localparam logic [3:0] B_MUL  = 4'd2;
  localparam logic [3:0] B_WALK = 4'd3;
  localparam logic [3:0] B_RD   = 4'd4;
  localparam logic [3:0] B_HGT  = 4'd5;
  localparam logic [3:0] B_SAT  = 4'd6;
  localparam logic [3:0] B_DIV  = 4'd7;
  localparam logic [3:0] B_OUT  = 4'd8;

  logic [3:0]                    state_r, state_nxt;
  gdr_pkg::desc_t                d_r;
  logic [gdr_pkg::KIND_W-1:0]    mem [DEPTH];
  logic [gdr_pkg::KIND_W-1:0]    rd_kind_r, kind_r;
  logic                          inmap_r, first_r, hit_r, side_r;
  logic                          sx_neg_r, sy_neg_r;
  logic [gdr_pkg::RDM_W-1:0]     rdxm_r, rdym_r;
  logic signed [MX_W-1:0]        mx_r, my_r;
  logic [A_W-1:0]                ax_r, ay_r, num_r;
  logic [P_W-1:0]                p_r, q_r;
  logic [STEP_W-1:0]             steps_r;
  logic [NR_W-1:0]               nr_r;
  logic [gdr_pkg::H_W+A_W-1:0]   tb_r;
  logic [CMP_W-1:0]              rem_r, dv_r;
  logic [HC_W-1:0]               hcnt_r;
  logic [gdr_pkg::H_W-1:0]       h_r;

  logic                          wr_en, wr_inmap, is_zero, chk_hit, xstep, sat, dge;
  logic [ADDR_W-1:0]             wr_addr, rd_addr;
  logic                          walk_inmap;
  logic [A_W-1:0]                fx, fy;
  logic [CMP_W-1:0]              nsh, tsh;
  logic [gdr_pkg::H_W-1:0]       two_r2;
  logic [gdr_pkg::ROW_W-1:0]     half_r;
  logic [gdr_pkg::H_W-2:0]       half_h;
  logic [gdr_pkg::H_W-1:0]       sum_h;
  logic [gdr_pkg::REG_W-1:0]     rows_m1;
  logic [gdr_pkg::ROW_W-1:0]     start_v, end_v;

  // Cell writes go straight from the head of the queue into the map.
  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign wr_inmap = (32'(q_data.cell_row) < MAP_DIM) && (32'(q_data.cell_col) < MAP_DIM);
  assign wr_en    = q_pop && !q_data.is_cast && wr_inmap;
  assign wr_addr  = ADDR_W'(q_data.cell_row) * ADDR_W'(MAP_DIM) + ADDR_W'(q_data.cell_col);

  // Walk read address; cells outside the map read as empty.
  assign walk_inmap = !mx_r[MX_W-1] && !my_r[MX_W-1] &&
                      (mx_r < MX_W'(MAP_DIM)) && (my_r < MX_W'(MAP_DIM));
  assign rd_addr    = ADDR_W'(mx_r) * ADDR_W'(MAP_DIM) + ADDR_W'(my_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= q_data.kind;
    if (state_r == B_RD) rd_kind_r <= mem[rd_addr];
  end

  // Distance to the first boundary on each axis.
  assign is_zero = (d_r.rdx == '0) && (d_r.rdy == '0);
  assign fx = A_W'(d_r.pos_x & FRAC_MASK);
  assign fy = A_W'(d_r.pos_y & FRAC_MASK);

  // A wall is entered when the cell just read is inside the map and not empty.
  assign chk_hit = !first_r && inmap_r && (rd_kind_r != '0);
  assign xstep   = (p_r < q_r);

  // Saturation test and the height division.
  assign two_r2 = {rows, 1'b0} + gdr_pkg::H_W'(2);
  assign nsh    = CMP_W'(nr_r) << F;
  assign tsh    = CMP_W'(tb_r) << gdr_pkg::DIR_FRAC;
  assign sat    = (nsh >= tsh);
  assign dge    = (rem_r >= dv_r);

  // Slice rows.
  assign half_r  = rows[gdr_pkg::REG_W-1:1];
  assign half_h  = h_r[gdr_pkg::H_W-1:1];
  assign sum_h   = gdr_pkg::H_W'(half_h) + gdr_pkg::H_W'(half_r);
  assign rows_m1 = rows - gdr_pkg::REG_W'(1);
  assign start_v = (gdr_pkg::REG_W'(half_r) > half_h) ?
                   gdr_pkg::ROW_W'(gdr_pkg::REG_W'(half_r) - half_h) : '0;
  assign end_v   = (sum_h > gdr_pkg::H_W'(rows_m1)) ?
                   rows_m1[gdr_pkg::ROW_W-1:0] : sum_h[gdr_pkg::ROW_W-1:0];

  assign o_push = (state_r == B_OUT) && !o_full;
  always_comb begin
    o_data.column     = d_r.column;
    o_data.draw_start = hit_r ? start_v : '0;
    o_data.draw_end   = hit_r ? end_v : '0;
    o_data.color      = hit_r ? gdr_pkg::kind_color(kind_r, side_r) : '0;
    o_data.hit_side   = hit_r && side_r;
    o_data.hit_found  = hit_r;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty && q_data.is_cast) state_nxt = B_INIT;
      end
      B_INIT: state_nxt = is_zero ? B_OUT : B_MUL;
      B_MUL:  state_nxt = B_WALK;
      B_WALK: begin
        priority if (chk_hit) state_nxt = B_HGT;
        else if (steps_r == STEP_W'(LIMIT)) state_nxt = B_OUT;
        else state_nxt = B_RD;
      end
      B_RD:  state_nxt = B_WALK;
      B_HGT: state_nxt = B_SAT;
      B_SAT: state_nxt = sat ? B_OUT : B_DIV;
      B_DIV: begin
        if (hcnt_r == '0) state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!o_full) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else state_r <= state_nxt;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) d_r <= q_data;
        hit_r <= 1'b0;
      end
      B_INIT: begin
        sx_neg_r <= d_r.rdx[gdr_pkg::RD_W-1];
        sy_neg_r <= d_r.rdy[gdr_pkg::RD_W-1];
        rdxm_r   <= gdr_pkg::RDM_W'(d_r.rdx[gdr_pkg::RD_W-1] ? -d_r.rdx : d_r.rdx);
        rdym_r   <= gdr_pkg::RDM_W'(d_r.rdy[gdr_pkg::RD_W-1] ? -d_r.rdy : d_r.rdy);
        mx_r     <= MX_W'(d_r.pos_x >> F);
        my_r     <= MX_W'(d_r.pos_y >> F);
        ax_r     <= d_r.rdx[gdr_pkg::RD_W-1] ? fx : ONE - fx;
        ay_r     <= d_r.rdy[gdr_pkg::RD_W-1] ? fy : ONE - fy;
        hit_r    <= 1'b0;
      end
      B_MUL: begin
        p_r     <= ax_r * rdym_r;
        q_r     <= ay_r * rdxm_r;
        steps_r <= '0;
        first_r <= 1'b1;
      end
      B_WALK: begin
        if (chk_hit) begin
          hit_r  <= 1'b1;
          kind_r <= rd_kind_r;
        end else if (steps_r != STEP_W'(LIMIT)) begin
          // Step along the axis whose boundary is nearer.
          if (xstep) begin
            num_r  <= ax_r;
            ax_r   <= ax_r + ONE;
            p_r    <= p_r + (P_W'(rdym_r) << F);
            mx_r   <= mx_r + (sx_neg_r ? {MX_W{1'b1}} : MX_W'(1));
            side_r <= 1'b0;
          end else begin
            num_r  <= ay_r;
            ay_r   <= ay_r + ONE;
            q_r    <= q_r + (P_W'(rdxm_r) << F);
            my_r   <= my_r + (sy_neg_r ? {MX_W{1'b1}} : MX_W'(1));
            side_r <= 1'b1;
          end
          steps_r <= steps_r + STEP_W'(1);
          first_r <= 1'b0;
        end
      end
      B_RD: begin
        inmap_r <= walk_inmap;
      end
      B_HGT: begin
        nr_r <= rows * (side_r ? rdym_r : rdxm_r);
        tb_r <= two_r2 * num_r;
      end
      B_SAT: begin
        h_r    <= sat ? (two_r2 - gdr_pkg::H_W'(1)) : '0;
        rem_r  <= nsh;
        dv_r   <= CMP_W'(num_r) << (gdr_pkg::DIR_FRAC + gdr_pkg::H_W - 1);
        hcnt_r <= HC_W'(gdr_pkg::H_W - 1);
      end
      B_DIV: begin
        if (dge) rem_r <= rem_r - dv_r;
        h_r    <= {h_r[gdr_pkg::H_W-2:0], dge};
        dv_r   <= dv_r >> 1;
        hcnt_r <= hcnt_r - HC_W'(1);
      end
      B_OUT: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/grid_dda_column_raycaster.sv
`timescale 1ns / 1ps

// Channel  | handshake              | payload
// in_      | in_push / in_full      | op, cell fields, column, position, direction, plane
// out_     | out_pop / out_empty    | column, draw rows, colour, side, hit flag
// cfg_     | cfg_valid / cfg_ready  | cfg_index, cfg_data (always ready)
//
// A cast runs 25 divider steps in the front; the back then walks the grid with one map
// read per grid step (up to 2*MAP_DIM steps) and, on a hit that does not saturate,
// divides for the height in 12 division steps.
// The front works on the next request while the back walks; a two-entry queue
// sits between them and a two-entry queue holds finished results.
// Reset sets both screen registers to 24; the tile map is not cleared.
module grid_dda_column_raycaster #(
  parameter int MAP_DIM         = 32,
  parameter int COORD_FRAC_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_op,
  input  logic [gdr_pkg::CELL_W-1:0]        in_cell_row,
  input  logic [gdr_pkg::CELL_W-1:0]        in_cell_col,
  input  logic [gdr_pkg::KIND_W-1:0]        in_cell_kind,
  input  logic [gdr_pkg::COL_W-1:0]         in_column,
  input  logic [gdr_pkg::POS_W-1:0]         in_pos_x,
  input  logic [gdr_pkg::POS_W-1:0]         in_pos_y,
  input  logic signed [gdr_pkg::DIR_W-1:0]  in_dir_x,
  input  logic signed [gdr_pkg::DIR_W-1:0]  in_dir_y,
  input  logic signed [gdr_pkg::DIR_W-1:0]  in_plane_x,
  input  logic signed [gdr_pkg::DIR_W-1:0]  in_plane_y,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [gdr_pkg::COL_W-1:0]         out_column,
  output logic [gdr_pkg::ROW_W-1:0]         out_draw_start,
  output logic [gdr_pkg::ROW_W-1:0]         out_draw_end,
  output logic [gdr_pkg::COLOR_W-1:0]       out_color,
  output logic                              out_hit_side,
  output logic                              out_hit_found,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gdr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gdr_pkg::REG_W-1:0]         cfg_data
);

  logic [gdr_pkg::REG_W-1:0] scr_cols_r, scr_rows_r;
  logic                      q_push, q_full, q_pop, q_empty;
  gdr_pkg::desc_t            q_wdata, q_rdata;
  logic                      o_push, o_full;
  gdr_pkg::res_t             o_wdata, o_rdata;

  // Screen registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_cols_r <= gdr_pkg::REG_RESET;
      scr_rows_r <= gdr_pkg::REG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gdr_pkg::REG_SCREEN_COLUMNS: scr_cols_r <= cfg_data;
        gdr_pkg::REG_SCREEN_ROWS:    scr_rows_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gdr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_op        (in_op),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .in_cell_kind (in_cell_kind),
    .in_column    (in_column),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_dir_x     (in_dir_x),
    .in_dir_y     (in_dir_y),
    .in_plane_x   (in_plane_x),
    .in_plane_y   (in_plane_y),
    .scr_cols     (gdr_pkg::clamp_reg(scr_cols_r)),
    .q_push       (q_push),
    .q_full       (q_full),
    .q_data       (q_wdata)
  );

  // Request queue between the two parts.
  gdr_fifo #(.T(gdr_pkg::desc_t), .DEPTH(2)) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  gdr_back #(.MAP_DIM(MAP_DIM), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_rdata),
    .rows    (gdr_pkg::clamp_reg(scr_rows_r)),
    .o_push  (o_push),
    .o_full  (o_full),
    .o_data  (o_wdata)
  );

  // Result queue.
  gdr_fifo #(.T(gdr_pkg::res_t), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .full  (o_full),
    .wdata (o_wdata),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (o_rdata)
  );

  assign out_column     = o_rdata.column;
  assign out_draw_start = o_rdata.draw_start;
  assign out_draw_end   = o_rdata.draw_end;
  assign out_color      = o_rdata.color;
  assign out_hit_side   = o_rdata.hit_side;
  assign out_hit_found  = o_rdata.hit_found;

endmodule

// File: sv/gdr_checker.sv
`timescale 1ns / 1ps
`include "grid_dda_column_raycaster_assert.svh"

// Port-level checks on the raycaster.
module gdr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic [gdr_pkg::COL_W-1:0]         out_column,
  input logic [gdr_pkg::ROW_W-1:0]         out_draw_start,
  input logic [gdr_pkg::ROW_W-1:0]         out_draw_end,
  input logic [gdr_pkg::COLOR_W-1:0]       out_color,
  input logic                              out_hit_side,
  input logic                              out_hit_found
);

  // A found wall always gives a slice that starts no lower than it ends.
  `GDR_ASSERT_IMP(a_slice_order, !out_empty && out_hit_found, out_draw_start <= out_draw_end)

  // A miss carries nothing but its column.
  `GDR_ASSERT_IMP(a_miss_clear, !out_empty && !out_hit_found,
    out_draw_start == '0 && out_draw_end == '0 && out_color == '0 && !out_hit_side)

  // Every wall colour is non-zero, even when halved.
  `GDR_ASSERT_IMP(a_hit_colour, !out_empty && out_hit_found, out_color != '0)

  // A waiting result stays until it is taken.
  `GDR_ASSERT_NXT(a_res_hold, !out_empty && !out_pop, !out_empty && $stable(out_column))

endmodule

bind grid_dda_column_raycaster gdr_checker u_gdr_checker (.*);
